[rtl/mpsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_pkg: shared types and codes of the monotone polygon scan converter
// Holds the operation and status codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package mpsc_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef logic [2:0] status_t;

	localparam status_t ST_READY    = 3'd0;
	localparam status_t ST_EMPTY    = 3'd1;
	localparam status_t ST_TOO_TALL = 3'd2;
	localparam status_t ST_TOO_MANY = 3'd3;
	localparam status_t ST_LINE     = 3'd4;
	localparam status_t ST_NO_MORE  = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    vtx_wr;
		logic    fetch_rd;
		logic    fetch_emit;
		logic    conv_init;
		logic    rd_first;
		logic    rd_next_i;
		logic    mm_update;
		logic    set_lines;
		logic    chain_start;
		logic    chain_second;
		logic    prev_load;
		logic    rd_step;
		logic    edge_latch;
		logic    div_start;
		logic    walk_init;
		logic    walk_step;
		logic    prev_from_cur;
		logic    emit_load;
		status_t code;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic n_over;
		logic mm_last;
		logic span_zero;
		logic span_tall;
		logic h_pos;
		logic div_done;
		logic walk_last;
		logic chain_end;
		logic second;
	} sts_t;

endpackage
`default_nettype wire

[rtl/mpsc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_in_if: request channel
// Carries vertex loads and scanline fetches with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpsc_in_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         last_vertex;

	modport source (output valid, op, vertex_x, vertex_y, last_vertex, input ready);
	modport sink   (input valid, op, vertex_x, vertex_y, last_vertex, output ready);
endinterface
`default_nettype wire

[rtl/mpsc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_out_if: result channel
// Carries status and scanline results with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpsc_out_if #(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 11
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   status;
	logic signed [COORD_BITS-1:0] line_y;
	logic signed [COORD_BITS:0]   start_x;
	logic signed [COORD_BITS:0]   end_x;
	logic [COUNT_BITS-1:0]        line_count;
	logic                         last_line;

	modport source (output valid, status, line_y, start_x, end_x, line_count, last_line,
		input ready);
	modport sink   (input valid, status, line_y, start_x, end_x, line_count, last_line,
		output ready);
endinterface
`default_nettype wire

[rtl/monotone_polygon_scan_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// A vertex load is written into the vertex store, if it has room, as it is taken; a fetch reads
// both chain stores into read registers, and the result register loads from them in S_FETCH.
// The last vertex starts the conversion: extreme search, then per chain and edge a setup and,
// for an edge of positive height, a division and a walk writing one scanline per step. One
// beat at a time: a request is taken only while the controller is idle and no result is held.
// Reset clears the controller, counts and top y at once; no memory clearing pass is run.
// ----------------------------------------------------------------------------
// monotone_polygon_scan_converter: top level
// Loads polygon vertices, steps both edge chains into scanline stores and
// returns one scanline span per fetch beat.
// ----------------------------------------------------------------------------
module monotone_polygon_scan_converter import mpsc_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_LINES    = 1024,
	parameter int COORD_BITS   = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mpsc_in_if.sink   in_ch,
	mpsc_out_if.source out_ch
);
	localparam int LW = $clog2(MAX_LINES + 1);

	// The controller and datapath talk only through these two bundles.
	cmd_t cmd;
	sts_t sts;

	// The controller owns both handshakes. A request beat is taken only when
	// the result register is empty, so every result is held until taken.
	mpsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_op    (in_ch.op),
		.in_last  (in_ch.last_vertex),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the vertex and chain memories, the edge stepper with
	// its divider, and the result register that drives the output payload.
	// The first chain walks backward through the vertex list, the second
	// forward; each fetch orders the two x values into a span.
	mpsc_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_LINES   (MAX_LINES),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_x          (in_ch.vertex_x),
		.in_y          (in_ch.vertex_y),
		.out_status    (out_ch.status),
		.out_line_y    (out_ch.line_y),
		.out_start_x   (out_ch.start_x),
		.out_end_x     (out_ch.end_x),
		.out_line_count(out_ch.line_count[LW-1:0]),
		.out_last_line (out_ch.last_line)
	);
endmodule
`default_nettype wire

[rtl/mpsc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_div: restoring divider
// Unsigned quotient and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpsc_div #(
	parameter int NW = 17,
	parameter int DW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quot,
	output logic [DW-1:0]      rem
);
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   quot_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dvs_q;
	logic [DW:0]     trial;
	logic [DW:0]     diff;
	logic            fits;

	always_comb begin
		trial = {rem_q, quot_q[NW-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(NW - 1));
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == CNTW'(NW - 1))) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q  <= '0;
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			quot_q <= {quot_q[NW-2:0], fits};
			rem_q  <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

[rtl/mpsc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_dp: scan converter datapath
// Vertex and chain memories, extreme search, edge stepper and result register.
// ----------------------------------------------------------------------------
module mpsc_dp import mpsc_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_LINES    = 1024,
	parameter int COORD_BITS   = 16,
	localparam int LW          = $clog2(MAX_LINES + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cmd_t                         cmd,
	output sts_t                              sts,
	input  wire logic signed [COORD_BITS-1:0] in_x,
	input  wire logic signed [COORD_BITS-1:0] in_y,
	output status_t                           out_status,
	output logic signed [COORD_BITS-1:0]      out_line_y,
	output logic signed [COORD_BITS:0]        out_start_x,
	output logic signed [COORD_BITS:0]        out_end_x,
	output logic [LW-1:0]                     out_line_count,
	output logic                              out_last_line
);
	localparam int CW   = COORD_BITS;
	localparam int XW   = CW + 1;
	localparam int MW   = XW + 1;
	localparam int EW   = LW + 2;
	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int VW   = $clog2(MAX_VERTICES + 2);
	localparam int LAW  = $clog2(MAX_LINES);
	localparam int CMPW = ((XW > LW) ? XW : LW) + 1;
	localparam int YW   = CW + LW;

	logic signed [CW-1:0] vx_mem [MAX_VERTICES];
	logic signed [CW-1:0] vy_mem [MAX_VERTICES];
	logic signed [XW-1:0] fc_mem [MAX_LINES];
	logic signed [XW-1:0] sc_mem [MAX_LINES];

	logic [VW-1:0]        total_q;
	logic [VW-1:0]        n_q;
	logic [LW-1:0]        lines_total_q;
	logic [LW-1:0]        fptr_q;
	logic signed [CW-1:0] top_y_q;

	logic signed [CW-1:0] vx_rd_q, vy_rd_q;
	logic signed [XW-1:0] fc_rd_q, sc_rd_q;
	logic [AW-1:0]        vaddr;
	logic                 vrd;

	logic [AW-1:0]        i_q, lo_q, hi_q, cur_q;
	logic [AW-1:0]        cur_bwd, cur_fwd, cur_nxt;
	logic signed [CW-1:0] ymin_q, ymax_q;
	logic signed [XW-1:0] span;

	logic signed [CW-1:0] px_q, py_q, cx_q, cy_q;
	logic signed [XW-1:0] dx, h;
	logic [XW-1:0]        w;
	logic                 dxneg_q, dxpos_q, second_q;
	logic [LW-1:0]        h_q, k_q, pos_q;

	logic                 div_done;
	logic [XW-1:0]        div_quot;
	logic [LW-1:0]        div_rem;

	logic signed [MW-1:0] major_q;
	logic signed [XW-1:0] x_q;
	logic signed [EW-1:0] err_q, e1;
	logic signed [MW-1:0] x_sum;
	logic                 carry;
	logic                 has_line;
	logic [YW-1:0]        y_sum;

	// Vertex store: written on loads, one registered read port.
	always_comb begin
		cur_bwd = (cur_q == '0) ? AW'(n_q - 1'b1) : cur_q - 1'b1;
		cur_fwd = ((VW'(cur_q) + 1'b1) == n_q) ? '0 : cur_q + 1'b1;
		cur_nxt = second_q ? cur_fwd : cur_bwd;
		vrd     = cmd.rd_first | cmd.rd_next_i | cmd.chain_start | cmd.rd_step;
		priority if (cmd.rd_first)    vaddr = '0;
		else if (cmd.rd_next_i)       vaddr = i_q + 1'b1;
		else if (cmd.chain_start)     vaddr = lo_q;
		else                          vaddr = cur_nxt;
	end

	always_ff @(posedge clk) begin
		if (cmd.vtx_wr && (total_q < VW'(MAX_VERTICES))) begin
			vx_mem[total_q[AW-1:0]] <= in_x;
			vy_mem[total_q[AW-1:0]] <= in_y;
		end
		if (vrd) begin
			vx_rd_q <= vx_mem[vaddr];
			vy_rd_q <= vy_mem[vaddr];
		end
	end

	// Persistent polygon state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= '0;
			lines_total_q <= '0;
			fptr_q        <= '0;
			top_y_q       <= '0;
		end else begin
			if (cmd.vtx_wr && (total_q <= VW'(MAX_VERTICES))) begin
				total_q <= total_q + 1'b1;
			end
			if (cmd.conv_init) begin
				total_q       <= '0;
				lines_total_q <= '0;
				fptr_q        <= '0;
			end
			if (cmd.set_lines) begin
				lines_total_q <= LW'($unsigned(span));
				top_y_q       <= ymin_q;
			end
			if (cmd.fetch_emit && has_line) begin
				fptr_q <= fptr_q + 1'b1;
			end
		end
	end

	// Top and bottom search, first of any ties.
	assign span = $signed({ymax_q[CW-1], ymax_q}) - $signed({ymin_q[CW-1], ymin_q});

	always_ff @(posedge clk) begin
		if (cmd.conv_init) begin
			n_q <= total_q;
		end
		if (cmd.rd_first) begin
			i_q <= '0;
		end else if (cmd.rd_next_i) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.mm_update) begin
			if (i_q == '0) begin
				ymin_q <= vy_rd_q;
				ymax_q <= vy_rd_q;
				lo_q   <= '0;
				hi_q   <= '0;
			end else if (vy_rd_q < ymin_q) begin
				ymin_q <= vy_rd_q;
				lo_q   <= i_q;
			end else if (vy_rd_q > ymax_q) begin
				ymax_q <= vy_rd_q;
				hi_q   <= i_q;
			end
		end
	end

	// Edge setup.
	always_comb begin
		dx = $signed({vx_rd_q[CW-1], vx_rd_q}) - $signed({px_q[CW-1], px_q});
		h  = $signed({vy_rd_q[CW-1], vy_rd_q}) - $signed({py_q[CW-1], py_q});
		w  = dx[XW-1] ? $unsigned(-dx) : $unsigned(dx);
	end

	mpsc_div #(
		.NW(XW),
		.DW(LW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(w),
		.divisor (LW'($unsigned(h))),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// Error term step: the quotient always, the direction step on carry.
	always_comb begin
		e1    = err_q + $signed(EW'(div_rem));
		carry = e1 > 0;
		x_sum = $signed({x_q[XW-1], x_q}) + major_q;
		if (carry) begin
			x_sum = dxpos_q ? x_sum + 2'sd1 : x_sum - 2'sd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.chain_start) begin
			cur_q    <= lo_q;
			pos_q    <= '0;
			second_q <= cmd.chain_second;
		end else if (cmd.rd_step) begin
			cur_q <= cur_nxt;
		end
		if (cmd.prev_load) begin
			px_q <= vx_rd_q;
			py_q <= vy_rd_q;
		end else if (cmd.prev_from_cur) begin
			px_q <= cx_q;
			py_q <= cy_q;
		end
		if (cmd.edge_latch) begin
			cx_q    <= vx_rd_q;
			cy_q    <= vy_rd_q;
			dxneg_q <= dx[XW-1];
			dxpos_q <= !dx[XW-1] && (dx != '0);
			h_q     <= LW'($unsigned(h));
		end
		if (cmd.walk_init) begin
			major_q <= dxpos_q ? $signed(MW'(div_quot)) : -$signed(MW'(div_quot));
			err_q   <= dxneg_q ? $signed(EW'(1)) - $signed(EW'(h_q)) : '0;
			x_q     <= $signed({px_q[CW-1], px_q}) + (second_q ? 2'sd1 : 2'sd0);
			k_q     <= '0;
		end else if (cmd.walk_step) begin
			x_q   <= x_sum[XW-1:0];
			err_q <= carry ? e1 - $signed(EW'(h_q)) : e1;
			k_q   <= k_q + 1'b1;
			pos_q <= pos_q + 1'b1;
		end
	end

	// Chain stores: written by the stepper, read by fetches.
	always_ff @(posedge clk) begin
		if (cmd.walk_step && (pos_q < lines_total_q)) begin
			if (second_q) begin
				sc_mem[pos_q[LAW-1:0]] <= x_q;
			end else begin
				fc_mem[pos_q[LAW-1:0]] <= x_q;
			end
		end
		if (cmd.fetch_rd) begin
			fc_rd_q <= fc_mem[fptr_q[LAW-1:0]];
			sc_rd_q <= sc_mem[fptr_q[LAW-1:0]];
		end
	end

	// Result register.
	assign has_line = fptr_q < lines_total_q;
	assign y_sum    = YW'(top_y_q) + YW'(fptr_q);

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_status     <= cmd.code;
			out_line_y     <= (cmd.code == ST_READY) ? top_y_q : '0;
			out_start_x    <= '0;
			out_end_x      <= '0;
			out_line_count <= (cmd.code == ST_READY) ? lines_total_q : '0;
			out_last_line  <= 1'b0;
		end else if (cmd.fetch_emit) begin
			out_line_count <= lines_total_q;
			if (has_line) begin
				out_status    <= ST_LINE;
				out_line_y    <= y_sum[CW-1:0];
				out_start_x   <= (fc_rd_q > sc_rd_q) ? sc_rd_q : fc_rd_q;
				out_end_x     <= (fc_rd_q > sc_rd_q) ? fc_rd_q : sc_rd_q;
				out_last_line <= (fptr_q + 1'b1) == lines_total_q;
			end else begin
				out_status    <= ST_NO_MORE;
				out_line_y    <= '0;
				out_start_x   <= '0;
				out_end_x     <= '0;
				out_last_line <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.n_over    = total_q > VW'(MAX_VERTICES);
		sts.mm_last   = (VW'(i_q) + 1'b1) == n_q;
		sts.span_zero = span == '0;
		sts.span_tall = CMPW'($unsigned(span)) > CMPW'(MAX_LINES);
		sts.h_pos     = !h[XW-1] && (h != '0);
		sts.div_done  = div_done;
		sts.walk_last = (k_q == h_q - 1'b1) || ((pos_q + 1'b1) == lines_total_q);
		sts.chain_end = (cur_q == hi_q) || (pos_q == lines_total_q);
		sts.second    = second_q;
	end
endmodule
`default_nettype wire

[rtl/mpsc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpsc_ctrl: scan converter controller
// Sequences loads, the conversion walk and fetches; owns the handshakes.
// ----------------------------------------------------------------------------
module mpsc_ctrl import mpsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic in_op,
	input  wire logic in_last,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_FETCH = 10'b0000000010,
		S_START = 10'b0000000100,
		S_MM    = 10'b0000001000,
		S_SPAN  = 10'b0000010000,
		S_BEGIN = 10'b0000100000,
		S_EDGE  = 10'b0001000000,
		S_DIV   = 10'b0010000000,
		S_WALK  = 10'b0100000000,
		S_NEXT  = 10'b1000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (in_op == OP_LOAD) begin
						cmd.vtx_wr = 1'b1;
						if (in_last) begin
							state_nxt = S_START;
						end
					end else begin
						cmd.fetch_rd = 1'b1;
						state_nxt    = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				cmd.fetch_emit = 1'b1;
				state_nxt      = S_IDLE;
			end
			S_START: begin
				cmd.conv_init = 1'b1;
				if (sts.n_over) begin
					cmd.emit_load = 1'b1;
					cmd.code      = ST_TOO_MANY;
					state_nxt     = S_IDLE;
				end else begin
					cmd.rd_first = 1'b1;
					state_nxt    = S_MM;
				end
			end
			S_MM: begin
				cmd.mm_update = 1'b1;
				if (sts.mm_last) begin
					state_nxt = S_SPAN;
				end else begin
					cmd.rd_next_i = 1'b1;
				end
			end
			S_SPAN: begin
				priority if (sts.span_zero) begin
					cmd.emit_load = 1'b1;
					cmd.code      = ST_EMPTY;
					state_nxt     = S_IDLE;
				end else if (sts.span_tall) begin
					cmd.emit_load = 1'b1;
					cmd.code      = ST_TOO_TALL;
					state_nxt     = S_IDLE;
				end else begin
					cmd.set_lines   = 1'b1;
					cmd.chain_start = 1'b1;
					state_nxt       = S_BEGIN;
				end
			end
			S_BEGIN: begin
				cmd.prev_load = 1'b1;
				cmd.rd_step   = 1'b1;
				state_nxt     = S_EDGE;
			end
			S_EDGE: begin
				cmd.edge_latch = 1'b1;
				if (sts.h_pos) begin
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV;
				end else begin
					state_nxt = S_NEXT;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.walk_init = 1'b1;
					state_nxt     = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_nxt = S_NEXT;
				end
			end
			S_NEXT: begin
				cmd.prev_from_cur = 1'b1;
				if (sts.chain_end) begin
					if (!sts.second) begin
						cmd.chain_start  = 1'b1;
						cmd.chain_second = 1'b1;
						state_nxt        = S_BEGIN;
					end else begin
						cmd.emit_load = 1'b1;
						cmd.code      = ST_READY;
						state_nxt     = S_IDLE;
					end
				end else begin
					cmd.rd_step = 1'b1;
					state_nxt   = S_EDGE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit_load || cmd.fetch_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

[dv/mpsc_scan_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsc_scan_checker: scoreboard of the monotone polygon scan converter
// Watches both channels, predicts every result beat from the accepted
// request beats and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module mpsc_scan_checker import mpsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	mpsc_in_if   in_ch,
	mpsc_out_if  out_ch,
	output int   fail_count,
	output int   pending,
	output int   beats_checked
);

	localparam int VTX_DEPTH  = 64;
	localparam int LINE_DEPTH = 1024;

	typedef struct {
		status_t            status;
		logic signed [15:0] line_y;
		logic signed [16:0] start_x;
		logic signed [16:0] end_x;
		logic [10:0]        line_count;
		logic               last_line;
	} scan_beat_t;

	scan_beat_t expected_beats[$];

	longint vx[VTX_DEPTH];
	longint vy[VTX_DEPTH];
	longint left_x[LINE_DEPTH];
	longint right_x[LINE_DEPTH];
	int     vtx_count;
	longint poly_top;
	int     span_lines;
	int     line_ptr;

	assign pending = expected_beats.size();

	task automatic report(string field, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
		fail_count++;
	endtask

	function automatic void step_edge(longint x1, longint y1, longint x2, longint y2,
		bit left, inout longint pos);
		longint dx, h, adv, w, major, rem, err, x;
		dx  = x2 - x1;
		h   = y2 - y1;
		adv = (dx > 0) ? 1 : -1;
		if (h <= 0) return;
		w     = (dx < 0) ? -dx : dx;
		major = (w / h) * adv;
		rem   = w % h;
		err   = (dx >= 0) ? 0 : (1 - h);
		x     = left ? x1 : x1 + 1;
		for (longint k = 0; k < h; k++) begin
			if (pos < span_lines) begin
				if (left) left_x[pos] = x;
				else right_x[pos] = x;
			end
			pos++;
			x   += major;
			err += rem;
			if (err > 0) begin
				x   += adv;
				err -= h;
			end
		end
	endfunction

	function automatic status_t scan_convert();
		int     n, lo, hi, prev, cur;
		longint ymin, ymax, span, pos, t;
		n  = vtx_count;
		lo = 0;
		hi = 0;
		vtx_count  = 0;
		span_lines = 0;
		line_ptr   = 0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			left_x[i]  = 0;
			right_x[i] = 0;
		end
		if (n > VTX_DEPTH) return ST_TOO_MANY;
		if (n == 0) return ST_EMPTY;
		ymin = vy[0];
		ymax = vy[0];
		for (int i = 1; i < n; i++) begin
			if (vy[i] < ymin) begin
				ymin = vy[i];
				lo   = i;
			end else if (vy[i] > ymax) begin
				ymax = vy[i];
				hi   = i;
			end
		end
		span = ymax - ymin;
		if (span <= 0) return ST_EMPTY;
		if (span > LINE_DEPTH) return ST_TOO_TALL;
		span_lines = int'(span);
		poly_top   = ymin;
		pos  = 0;
		prev = lo;
		cur  = lo;
		do begin
			cur = (cur + n - 1) % n;
			step_edge(vx[prev], vy[prev], vx[cur], vy[cur], 1'b1, pos);
			prev = cur;
		end while (cur != hi);
		pos  = 0;
		prev = lo;
		cur  = lo;
		do begin
			cur = (cur + 1) % n;
			step_edge(vx[prev], vy[prev], vx[cur], vy[cur], 1'b0, pos);
			prev = cur;
		end while (cur != hi);
		for (int i = 0; i < span_lines; i++) begin
			if (left_x[i] > right_x[i]) begin
				t          = left_x[i];
				left_x[i]  = right_x[i];
				right_x[i] = t;
			end
		end
		return ST_READY;
	endfunction

	// Prediction of one accepted request beat.
	always @(posedge clk or negedge arst_n) begin
		scan_beat_t b;
		if (!arst_n) begin
			expected_beats.delete();
			vtx_count  = 0;
			poly_top   = 0;
			span_lines = 0;
			line_ptr   = 0;
		end else if (in_ch.valid && in_ch.ready) begin
			b = '{ST_READY, '0, '0, '0, '0, 1'b0};
			if (in_ch.op == OP_LOAD) begin
				if (vtx_count < VTX_DEPTH) begin
					vx[vtx_count] = longint'(in_ch.vertex_x);
					vy[vtx_count] = longint'(in_ch.vertex_y);
				end
				if (vtx_count <= VTX_DEPTH) vtx_count++;
				if (in_ch.last_vertex) begin
					b.status = scan_convert();
					if (b.status == ST_READY) begin
						b.line_y     = poly_top[15:0];
						b.line_count = span_lines[10:0];
					end
					expected_beats.push_back(b);
				end
			end else begin
				b.line_count = span_lines[10:0];
				if (line_ptr < span_lines) begin
					b.status    = ST_LINE;
					b.line_y    = 16'(poly_top + line_ptr);
					b.start_x   = left_x[line_ptr][16:0];
					b.end_x     = right_x[line_ptr][16:0];
					b.last_line = (line_ptr + 1 == span_lines);
					line_ptr++;
				end else begin
					b.status = ST_NO_MORE;
				end
				expected_beats.push_back(b);
			end
		end
	end

	// Comparison of one accepted result beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		scan_beat_t w;
		if (!arst_n) begin
			fail_count    = 0;
			beats_checked = 0;
		end else if (out_ch.valid && out_ch.ready) begin
			beats_checked++;
			if (expected_beats.size() == 0) begin
				$display("unexpected result beat, status %0d at %0t", out_ch.status, $realtime);
				fail_count++;
			end else begin
				w = expected_beats.pop_front();
				if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
				if (out_ch.line_y !== w.line_y) report("line_y", out_ch.line_y, w.line_y);
				if (out_ch.start_x !== w.start_x) report("start_x", out_ch.start_x, w.start_x);
				if (out_ch.end_x !== w.end_x) report("end_x", out_ch.end_x, w.end_x);
				if (out_ch.line_count !== w.line_count)
					report("line_count", out_ch.line_count, w.line_count);
				if (out_ch.last_line !== w.last_line)
					report("last_line", out_ch.last_line, w.last_line);
			end
		end
	end

endmodule

[dv/monotone_polygon_scan_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monotone_polygon_scan_converter_test: top of the scan converter testbench
// Loads directed and random monotone polygons plus degenerate ones, fetches
// their scanlines under random sender gaps and receiver stalls, and lets the
// checker score every result beat.
// ----------------------------------------------------------------------------
module monotone_polygon_scan_converter_test;
	import mpsc_pkg::*;

	// The longest conversion, of about 70 vertices and 1024 lines, ends well inside this limit, so a
	// quiet stretch this long can only mean the block has hung.
	localparam int QUIET_LIMIT = 40000;

	logic clk;
	logic arst_n;

	mpsc_in_if  in_ch();
	mpsc_out_if out_ch();

	int fail_count;
	int pending;
	int beats_checked;

	int beats_sent;
	int polygons_sent;
	int burst_left;
	int stall_pct;
	int quiet_cycles;

	// Current polygon, in load order.
	int px[80];
	int py[80];
	int poly_n;

	monotone_polygon_scan_converter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	mpsc_scan_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver changes its stall mood at random: sometimes it never stalls, sometimes it
	// drops ready on most cycles.
	always @(posedge clk) begin
		if ($urandom_range(0, 255) == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					stall_pct = 0;
				end
				1: begin
					stall_pct = 30;
				end
				default: begin
					stall_pct = 75;
				end
			endcase
		end
		out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog: any accepted beat on either channel counts as progress.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Sends one request beat. The sender works in bursts; when a burst runs out the valid
	// line may drop for a random gap, otherwise it stays high into the next beat.
	task automatic send_beat(logic op, int x, int y, logic last);
		int gap;
		in_ch.valid       <= 1'b1;
		in_ch.op          <= op;
		in_ch.vertex_x    <= x[15:0];
		in_ch.vertex_y    <= y[15:0];
		in_ch.last_vertex <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		beats_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 8);
		end
	endtask

	// Fetch beats carry junk in the vertex fields, which the block must ignore.
	task automatic fetch_lines(int count);
		repeat (count) send_beat(OP_FETCH, $urandom, $urandom, $urandom_range(0, 1));
	endtask

	task automatic load_polygon();
		for (int i = 0; i < poly_n; i++) send_beat(OP_LOAD, px[i], py[i], i == poly_n - 1);
		polygons_sent++;
	endtask

	// Builds a y-monotone polygon: a unique top, a descending forward chain, a unique bottom
	// and an ascending return chain, all rotated by a random amount. Interior vertices sit
	// strictly between top and bottom so the first-of-ties rule never hides a chain, and
	// every scanline gets written by both chains.
	task automatic build_polygon(int top, int span, int nfwd, int nback, int xlo, int xhi);
		int ring_y[80];
		int ring_x[80];
		int m, off, rot;
		if (span < 2) begin
			nfwd  = 0;
			nback = 0;
		end
		m = 0;
		ring_y[m++] = top;
		off = 1;
		for (int i = 0; i < nfwd; i++) begin
			off = $urandom_range(off, span - 1);
			ring_y[m++] = top + off;
		end
		ring_y[m++] = top + span;
		off = span - 1;
		for (int i = 0; i < nback; i++) begin
			off = $urandom_range(1, off);
			ring_y[m++] = top + off;
		end
		for (int i = 0; i < m; i++) ring_x[i] = xlo + int'($urandom_range(0, xhi - xlo));
		rot    = $urandom_range(0, m - 1);
		poly_n = m;
		for (int i = 0; i < m; i++) begin
			px[i] = ring_x[(i + rot) % m];
			py[i] = ring_y[(i + rot) % m];
		end
	endtask

	task automatic run_polygon(int top, int span, int nfwd, int nback, int xlo, int xhi,
		int extra);
		build_polygon(top, span, nfwd, nback, xlo, xhi);
		load_polygon();
		fetch_lines(span + extra);
	endtask

	// Drops valid so no beat is repeated, then waits for every expected result.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int span, top, wide;
		arst_n            = 1'b0;
		beats_sent        = 0;
		polygons_sent     = 0;
		burst_left        = 4;
		in_ch.valid       <= 1'b0;
		in_ch.op          <= OP_LOAD;
		in_ch.vertex_x    <= '0;
		in_ch.vertex_y    <= '0;
		in_ch.last_vertex <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A fetch straight after reset finds no lines.
		fetch_lines(1);
		// A lone vertex is an empty polygon.
		send_beat(OP_LOAD, 100, -5, 1'b1);
		// A flat triangle has no height.
		send_beat(OP_LOAD, -32768, 7, 1'b0);
		send_beat(OP_LOAD, 32767, 7, 1'b0);
		send_beat(OP_LOAD, 0, 7, 1'b1);
		// Full y range is far too tall.
		send_beat(OP_LOAD, 0, -32768, 1'b0);
		send_beat(OP_LOAD, 5, 32767, 1'b0);
		send_beat(OP_LOAD, -5, 0, 1'b1);
		// Extreme x at the top edge of the y range, with one fetch past the end.
		send_beat(OP_LOAD, -32768, -32768, 1'b0);
		send_beat(OP_LOAD, 32767, -32765, 1'b0);
		send_beat(OP_LOAD, -32768, -32766, 1'b1);
		fetch_lines(4);
		// Two vertices, one line, bottom at the largest y.
		send_beat(OP_LOAD, 32767, 32766, 1'b0);
		send_beat(OP_LOAD, 32767, 32767, 1'b1);
		fetch_lines(2);
		// Vertical, y-major and x-major edges in one quad.
		send_beat(OP_LOAD, 10, 0, 1'b0);
		send_beat(OP_LOAD, 40, 4, 1'b0);
		send_beat(OP_LOAD, 13, 8, 1'b0);
		send_beat(OP_LOAD, 10, 4, 1'b1);
		fetch_lines(8);

		// Let every expected result arrive before the random part starts.
		drain();

		// Random part: mostly small monotone polygons read out fully, with a sprinkling of
		// degenerate polygons, overlong vertex lists and stray fetches.
		while (beats_sent < 900) begin
			case ($urandom_range(0, 19))
				0: begin
					send_beat(OP_LOAD, $urandom, $urandom, 1'b1);
				end
				1: begin
					top = $urandom_range(0, 1000) - 500;
					for (int i = 0; i < 4; i++) send_beat(OP_LOAD, $urandom, top, i == 3);
					fetch_lines(1);
				end
				2: begin
					span = $urandom_range(1025, 3000);
					build_polygon(-1500, span, 1, 1, -100, 100);
					load_polygon();
					fetch_lines(1);
				end
				3: begin
					fetch_lines($urandom_range(1, 3));
				end
				4: begin
					if ($urandom_range(0, 4) == 0) begin
						for (int i = 0; i < 66 + $urandom_range(0, 4); i++)
							send_beat(OP_LOAD, $urandom, $urandom, 1'b0);
						send_beat(OP_LOAD, $urandom, $urandom, 1'b1);
						fetch_lines(1);
					end
				end
				default: begin
					span = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120)
						: $urandom_range(1, 12);
					top  = int'($urandom_range(0, 65535 - span)) - 32768;
					wide = $urandom_range(0, 2);
					if (wide == 0) begin
						run_polygon(top, span, $urandom_range(0, 3), $urandom_range(0, 3),
							-32768, 32767, $urandom_range(0, 1));
					end else begin
						run_polygon(top, span, $urandom_range(0, 3), $urandom_range(0, 3),
							-40, 40, $urandom_range(0, 1));
					end
				end
			endcase
			if ($urandom_range(0, 7) == 0) drain();
		end
		// One polygon of the largest legal height with many edges; its top lines are read.
		build_polygon(-512, 1024, 20, 20, -32768, 32767);
		load_polygon();
		fetch_lines(64);

		drain();
		repeat (60) @(posedge clk);

		$display("sent %0d request beats in %0d polygons, checked %0d result beats",
			beats_sent, polygons_sent, beats_checked);
		$display("covered status codes, edge slopes, extreme coordinates and readout past end");
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[monotone_polygon_scan_converter.f]
rtl/mpsc_pkg.sv
rtl/mpsc_in_if.sv
rtl/mpsc_out_if.sv
rtl/mpsc_div.sv
rtl/mpsc_dp.sv
rtl/mpsc_ctrl.sv
rtl/monotone_polygon_scan_converter.sv
dv/mpsc_scan_checker.sv
dv/monotone_polygon_scan_converter_test.sv
